[design/pdm_pkg.sv]
// ----------------------------------------------------------------------------
// pdm_pkg: shared constants and types for the dual motor PID mixer
// Field widths, fixed point positions, register indexes, sequencer states
// and the request/status bundles of the iterative divider.
// ----------------------------------------------------------------------------
package pdm_pkg;

	// fixed point positions
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 8;

	// port field widths
	localparam int ANGLE_W   = 17;
	localparam int TGT_W     = 9;
	localparam int ELAPSED_W = 16;
	localparam int GAIN_W    = 16;
	localparam int THR_W     = 12;
	localparam int OFS_W     = 8;
	localparam int PWM_L_W   = 13;
	localparam int PWM_R_W   = 12;
	localparam int CORR_W    = 11;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LEFT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_RIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_OFS  = 3'd7;

	// register reset values
	localparam logic [THR_W-1:0] THR_LEFT_RST  = 12'd1430;
	localparam logic [THR_W-1:0] THR_RIGHT_RST = 12'd1345;
	localparam logic [THR_W-1:0] SPEED_MIN_RST = 12'd1325;
	localparam logic [THR_W-1:0] SPEED_MAX_RST = 12'd1500;
	localparam logic [OFS_W-1:0] STABLE_OFS_RST = 8'd82;

	// datapath widths
	localparam int TQ_W      = TGT_W + ANGLE_FRAC_BITS;
	localparam int ERR_W     = ((ANGLE_W > TQ_W) ? ANGLE_W : TQ_W) + 1;
	localparam int DERR_W    = ERR_W + 1;
	localparam int P_W       = GAIN_W + ERR_W;
	localparam int INT_W     = 32;
	localparam int ACC_W     = P_W + 1;
	localparam int D1_W      = GAIN_W + DERR_W;
	localparam int DSCALE    = 1000;
	localparam int DSCALE_W  = 10;
	localparam int DPROD_W   = D1_W + DSCALE_W;
	localparam int DIV_W     = DPROD_W - 1;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int MUL_A_W   = D1_W;
	localparam int MUL_W     = MUL_A_W + GAIN_W + 1;
	localparam int SUM_W     = DPROD_W + 2;
	localparam int SUM_SHIFT = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
	localparam int CORR_LIM  = 1000;
	localparam int INT_WIN   = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D1,
		ST_MUL_D2,
		ST_DIV_GO,
		ST_DIV,
		ST_SUM,
		ST_TRUNC,
		ST_MIX
	} pdm_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [ELAPSED_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quotient;
	} div_stat_t;

endpackage

[design/pdm_div.sv]
// ----------------------------------------------------------------------------
// pdm_div: unsigned restoring divider
// One quotient bit per cycle; busy drops once the last bit has been formed.
// ----------------------------------------------------------------------------
module pdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pdm_pkg::div_req_t req,
	output pdm_pkg::div_stat_t stat
);
	import pdm_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [ELAPSED_W-1:0] rem_q;
	logic [ELAPSED_W-1:0] dsr_q;
	logic [ELAPSED_W:0]   rem_sh;
	logic                 ge;
	logic [ELAPSED_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];
		end
	end

	assign stat.busy     = busy_q;
	assign stat.quotient = quo_q;

endmodule

[design/pid_dual_motor_mixer.sv]
// ----------------------------------------------------------------------------
// pid_dual_motor_mixer: PID tilt controller mixed onto two motor drives
// Conditional integration, saturating integral, derivative scaled by
// 1000/elapsed_ms, correction clamped and split onto left and right drives.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | sink      | in_valid / in_ready   | angle, target_angle, elapsed_ms
//  out     | source    | out_valid / out_ready | pwm_left, pwm_right, correction,
//          |           |                       | stable
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A request is accepted only while the sequencer is idle; when elapsed_ms is zero
//  the 44-step restoring divider for the derivative is skipped.
//  The products P, I, D*gain and D*1000 go one after another through one shared
//  multiplier.
//  Reset loads the register defaults and clears the previous error, the integral
//  and the output valid; no clearing pass is needed.
//  A stalled result holds in the output register; the next request is accepted
//  meanwhile and waits in the final mixing step until the result is taken.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_dual_motor_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pdm_pkg::ANGLE_W-1:0]   angle,
	input  logic signed [pdm_pkg::TGT_W-1:0]     target_angle,
	input  logic        [pdm_pkg::ELAPSED_W-1:0] elapsed_ms,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [pdm_pkg::PWM_L_W-1:0]   pwm_left,
	output logic        [pdm_pkg::PWM_R_W-1:0]   pwm_right,
	output logic signed [pdm_pkg::CORR_W-1:0]    correction,
	output logic                                 stable,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [pdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdm_pkg::*;

	typedef enum logic [1:0] {
		MSEL_P,
		MSEL_I,
		MSEL_D1,
		MSEL_D2
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     div_start;
		logic     out_load;
	} seq_ctl_t;

	localparam logic signed [ERR_W-1:0] ONE_Q     = ERR_W'(1 << ANGLE_FRAC_BITS);
	localparam logic signed [ERR_W-1:0] ONE_Q_N   = -ONE_Q;
	localparam logic signed [ERR_W-1:0] IWIN_Q    = ERR_W'(INT_WIN << ANGLE_FRAC_BITS);
	localparam logic signed [ERR_W-1:0] IWIN_Q_N  = -IWIN_Q;
	localparam logic signed [SUM_W-1:0] CLIM_P    = SUM_W'(CORR_LIM);
	localparam logic signed [SUM_W-1:0] CLIM_N    = -CLIM_P;
	localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << SUM_SHIFT) - 1);

	// configuration registers
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [THR_W-1:0]  thr_left_q, thr_right_q, speed_min_q, speed_max_q;
	logic [OFS_W-1:0]  stable_ofs_q;

	// controller state
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [INT_W-1:0] integral_q;

	// per-request working registers
	pdm_state_t               state_q, state_d;
	seq_ctl_t                 ctl;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DERR_W-1:0]  derr_q;
	logic [ELAPSED_W-1:0]      elapsed_q;
	logic signed [P_W-1:0]     p_q;
	logic signed [D1_W-1:0]    d1_q;
	logic signed [DPROD_W-1:0] dprod_q;
	logic signed [DPROD_W-1:0] d_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [CORR_W-1:0]  corr_q;

	// output register
	logic                      out_valid_q;
	logic [PWM_L_W-1:0]        pwm_left_q;
	logic [PWM_R_W-1:0]        pwm_right_q;
	logic signed [CORR_W-1:0]  corr_out_q;
	logic                      stable_q;

	logic in_acc;
	logic signed [ERR_W-1:0]   err_in;
	logic signed [DERR_W-1:0]  derr_in;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0]         mul_b;
	logic signed [MUL_W-1:0]   mul_p;
	logic signed [ACC_W-1:0]   int_acc;
	logic                      int_hi, int_lo, int_win;
	logic [DPROD_W-1:0]        dprod_mag;
	div_req_t                  div_req;
	div_stat_t                 div_stat;
	logic signed [SUM_W-1:0]   sum_b;
	logic signed [SUM_W-1:0]   sum_t;
	logic signed [CORR_W-1:0]  corr_d;
	logic signed [THR_W+1:0]   left_raw, right_raw, left_c, right_c;
	logic signed [THR_W+1:0]   smin_x, smax_x;
	logic                      stable_d;
	logic [PWM_L_W-1:0]        left_fin;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	// error in angle fraction bits; always fits ERR_W
	assign err_in  = ERR_W'(angle) - (ERR_W'(target_angle) <<< ANGLE_FRAC_BITS);
	assign derr_in = DERR_W'(err_in) - DERR_W'(last_error_q);

	// configuration writes, masked to the register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			thr_left_q   <= THR_LEFT_RST;
			thr_right_q  <= THR_RIGHT_RST;
			speed_min_q  <= SPEED_MIN_RST;
			speed_max_q  <= SPEED_MAX_RST;
			stable_ofs_q <= STABLE_OFS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAIN_P:     gain_p_q     <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:     gain_i_q     <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:     gain_d_q     <= cfg_data[GAIN_W-1:0];
				CFG_THR_LEFT:   thr_left_q   <= cfg_data[THR_W-1:0];
				CFG_THR_RIGHT:  thr_right_q  <= cfg_data[THR_W-1:0];
				CFG_SPEED_MIN:  speed_min_q  <= cfg_data[THR_W-1:0];
				CFG_SPEED_MAX:  speed_max_q  <= cfg_data[THR_W-1:0];
				CFG_STABLE_OFS: stable_ofs_q <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_MUL_P;
			ST_MUL_P:  state_d = ST_MUL_I;
			ST_MUL_I:  state_d = ST_MUL_D1;
			ST_MUL_D1: state_d = ST_MUL_D2;
			// no elapsed time: derivative is zero, skip the divider
			ST_MUL_D2: state_d = (elapsed_q == '0) ? ST_SUM : ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV:    if (!div_stat.busy) state_d = ST_SUM;
			ST_SUM:    state_d = ST_TRUNC;
			ST_TRUNC:  state_d = ST_MIX;
			// hold here while the previous result is still unread
			ST_MIX:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '{mul_sel: MSEL_P, div_start: 1'b0, out_load: 1'b0};
		case (state_q)
			ST_MUL_P:  ctl.mul_sel = MSEL_P;
			ST_MUL_I:  ctl.mul_sel = MSEL_I;
			ST_MUL_D1: ctl.mul_sel = MSEL_D1;
			ST_MUL_D2: ctl.mul_sel = MSEL_D2;
			ST_DIV_GO: ctl.div_start = 1'b1;
			ST_MIX:    ctl.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------- shared multiplier
	always_comb begin
		case (ctl.mul_sel)
			MSEL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = gain_p_q;
			end
			MSEL_I: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = gain_i_q;
			end
			MSEL_D1: begin
				mul_a = MUL_A_W'(derr_q);
				mul_b = gain_d_q;
			end
			MSEL_D2: begin
				mul_a = MUL_A_W'(d1_q);
				mul_b = GAIN_W'(DSCALE);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_W'(mul_a) * MUL_W'($signed({1'b0, mul_b}));

	// integral update with saturation to the signed 32-bit range
	assign int_acc = ACC_W'(integral_q) + ACC_W'($signed(mul_p[P_W-1:0]));
	assign int_hi  = !int_acc[ACC_W-1] && (int_acc[ACC_W-2:INT_W-1] != '0);
	assign int_lo  = int_acc[ACC_W-1] && !(&int_acc[ACC_W-2:INT_W-1]);
	assign int_win = (err_q < IWIN_Q) && (err_q > IWIN_Q_N);

	// divider works on the magnitude; sign is restored afterwards
	assign dprod_mag = dprod_q[DPROD_W-1] ? -dprod_q : dprod_q;

	assign div_req.start    = ctl.div_start;
	assign div_req.dividend = dprod_mag[DIV_W-1:0];
	assign div_req.divisor  = elapsed_q;

	pdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// controller state: previous error and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			integral_q   <= '0;
		end else begin
			if (in_acc) begin
				last_error_q <= err_in;
			end
			if (state_q == ST_MUL_I && int_win) begin
				if (int_hi) begin
					integral_q <= {1'b0, {(INT_W-1){1'b1}}};
				end else if (int_lo) begin
					integral_q <= {1'b1, {(INT_W-1){1'b0}}};
				end else begin
					integral_q <= int_acc[INT_W-1:0];
				end
			end
		end
	end

	// sum truncated toward zero: bias negative values before the shift
	assign sum_b = sum_q + (sum_q[SUM_W-1] ? TRUNC_BIAS : '0);
	assign sum_t = sum_b >>> SUM_SHIFT;

	always_comb begin
		if (sum_t > CLIM_P) begin
			corr_d = CORR_W'(CLIM_P);
		end else if (sum_t < CLIM_N) begin
			corr_d = CORR_W'(CLIM_N);
		end else begin
			corr_d = sum_t[CORR_W-1:0];
		end
	end

	// working registers along the sequence
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					err_q     <= err_in;
					derr_q    <= derr_in;
					elapsed_q <= elapsed_ms;
				end
			end
			ST_MUL_P:  p_q  <= $signed(mul_p[P_W-1:0]);
			ST_MUL_D1: d1_q <= $signed(mul_p[D1_W-1:0]);
			ST_MUL_D2: begin
				dprod_q <= $signed(mul_p[DPROD_W-1:0]);
				d_q     <= '0;
			end
			ST_DIV: begin
				if (!div_stat.busy) begin
					d_q <= dprod_q[DPROD_W-1] ? -DPROD_W'(div_stat.quotient)
						: DPROD_W'(div_stat.quotient);
				end
			end
			ST_SUM:   sum_q  <= SUM_W'(p_q) + SUM_W'(integral_q) + SUM_W'(d_q);
			ST_TRUNC: corr_q <= corr_d;
			default: ;
		endcase
	end

	// --------------------------------------------------------------- mixing
	assign smin_x    = $signed({2'b00, speed_min_q});
	assign smax_x    = $signed({2'b00, speed_max_q});
	assign left_raw  = $signed({2'b00, thr_left_q}) + (THR_W+2)'(corr_q);
	assign right_raw = $signed({2'b00, thr_right_q}) - (THR_W+2)'(corr_q);

	// minimum first, then maximum: inverted limits give speed_max
	always_comb begin
		left_c = left_raw;
		if (left_c < smin_x) left_c = smin_x;
		if (left_c > smax_x) left_c = smax_x;
		right_c = right_raw;
		if (right_c < smin_x) right_c = smin_x;
		if (right_c > smax_x) right_c = smax_x;
	end

	assign stable_d = (err_q > ONE_Q_N) && (err_q < ONE_Q);
	assign left_fin = stable_d
		? {1'b0, right_c[THR_W-1:0]} + PWM_L_W'(stable_ofs_q)
		: {1'b0, left_c[THR_W-1:0]};

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			pwm_left_q  <= left_fin;
			pwm_right_q <= right_c[PWM_R_W-1:0];
			corr_out_q  <= corr_q;
			stable_q    <= stable_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign pwm_left   = pwm_left_q;
	assign pwm_right  = pwm_right_q;
	assign correction = corr_out_q;
	assign stable     = stable_q;

endmodule

[design/pdm_checker.sv]
// ----------------------------------------------------------------------------
// pdm_checker: port-level checks for the dual motor PID mixer
// Watches the request and result channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pdm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [pdm_pkg::PWM_L_W-1:0]   pwm_left,
	input logic        [pdm_pkg::PWM_R_W-1:0]   pwm_right,
	input logic signed [pdm_pkg::CORR_W-1:0]    correction,
	input logic                                 stable
);
	import pdm_pkg::*;

	localparam logic signed [CORR_W-1:0] LIM_P = CORR_W'(CORR_LIM);
	localparam logic signed [CORR_W-1:0] LIM_N = -LIM_P;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_left)
			&& $stable(pwm_right) && $stable(correction) && $stable(stable))
		else $error("result changed while stalled");

	// one request at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while the previous one is in work");

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (correction <= LIM_P) && (correction >= LIM_N))
		else $error("correction outside its clamp");

	// stable left drive sits at the right drive plus a nonnegative offset
	a_stable_mix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stable |-> pwm_left >= PWM_L_W'(pwm_right))
		else $error("stable left drive below right drive");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stable |-> !pwm_left[PWM_L_W-1])
		else $error("clamped left drive out of range");

endmodule

bind pid_dual_motor_mixer pdm_checker u_pdm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pwm_left   (pwm_left),
	.pwm_right  (pwm_right),
	.correction (correction),
	.stable     (stable)
);
